FILE: sv/sdf3_pkg.sv
`default_nettype none
package sdf3_pkg;

  typedef enum logic [5:0] {
    S_IDLE, S_OMEGA_DIV, S_X_MUL, S_X_WB, S_X2_MUL, S_X2_WB, S_X3_MUL, S_X3_WB,
    S_CSQ_MUL, S_CSQ_WB, S_CCU_MUL, S_CCU_WB, S_DEN, S_EX_DIV, S_CHG,
    S_SQ_MUL, S_SQ_WB, S_LIM_MUL, S_LIM_WB, S_LSQ_MUL, S_LSQ_WB, S_SQRT,
    S_SC_MUL, S_SC_START, S_SC_DIV, S_A_MUL, S_A_WB, S_T_MUL, S_T_WB,
    S_C_MUL, S_C_WB, S_V_MUL, S_V_WB, S_F_MUL, S_F_WB, S_O_PRE, S_O_MUL,
    S_O_WB, S_DONE
  } state_e;

  localparam logic [1:0] CFG_SMOOTH_TIME = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED   = 2'd1;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == '0 || v[65:31] == '1) r = v[31:0];
    else if (v[65]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

  // Clamp an unsigned quotient to the positive signed 32-bit range.
  function automatic logic signed [31:0] usat32(input logic [63:0] q);
    logic signed [31:0] r;
    if (q[63:31] != '0) r = 32'sh7FFF_FFFF;
    else r = $signed({1'b0, q[30:0]});
    return r;
  endfunction

  function automatic logic signed [31:0] add32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

endpackage
`default_nettype wire

FILE: sv/smooth_damp_follower_3d_top.sv
// Critically damped 3-D follower ("smooth damp") in signed fixed point.
// Input beats on s_axis carry the current position, the goal and a Q0.16 time
// step; each accepted beat yields exactly one m_axis beat with the new
// position, the new velocity and a snapped flag in tuser. The velocity vector
// is kept between beats and cleared by reset, which also loads smooth_time
// with 1.0 and max_speed with its largest value.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle; the block does not enforce this. One beat is worked through by a
// sequencer around a single 32x32 multiplier, a 1-bit-per-cycle restoring
// divider and a 2-bit-per-cycle square root. When the speed limit engages,
// the square root and three more divisions are added to the work on a beat.
// The divider's work on each quotient takes up most of the time in a beat.
// s_axis_tready is high only while no beat is in work. A finished result sits
// in the output register; if the receiver stalls, the next beat can be taken
// and worked, and it waits in its final step until the output register frees.
`default_nettype none
module smooth_damp_follower_3d_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [30:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, time_step
  input  wire logic [207:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_x, next_y, next_z, speed_x, speed_y, speed_z
  output logic [191:0]      m_axis_tdata,
  // snapped
  output logic              m_axis_tuser
);
  import sdf3_pkg::*;

  localparam longint QONE    = longint'(1) << FRAC_BITS;
  localparam longint MINS0   = (QONE + 5000) / 10000;
  localparam longint MINS    = (MINS0 < 1) ? 1 : MINS0;
  localparam longint COEF_SQ = (48 * QONE + 50) / 100;
  localparam longint COEF_CU = (235 * QONE + 500) / 1000;
  localparam logic [63:0] NUM_OMEGA = 64'(1) << (2 * FRAC_BITS + 1);
  localparam logic [63:0] NUM_EX    = 64'(1) << (2 * FRAC_BITS);

  function automatic logic signed [31:0] qsh(input logic signed [63:0] p,
                                             input int unsigned sh);
    logic signed [63:0] bias;
    logic signed [63:0] t;
    bias = p[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    t = (p + bias) >>> sh;
    return sat32(66'(t));
  endfunction

  state_e state_q, state_d;

  logic [30:0] smooth_time_q, max_speed_q, st_q;
  logic [15:0] dt_q;
  logic signed [31:0] cur_q [3], goal_q [3], chg_q [3], gmc_q [3];
  logic signed [31:0] vel_q [3], nvel_q [3], nxt_q [3];
  logic signed [31:0] omega_q, x_q, x2_q, x3_q, ex_q, limit_q, t_q, tmp_q, base_q;
  logic signed [65:0] acc_q;
  logic [63:0] magsq_q;
  logic [32:0] mag_q;
  logic [1:0]  idx_q;
  logic        neg_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] p_q;

  // Divider and square root state.
  logic        div_run_q, sqrt_run_q;
  logic [63:0] dq_q;
  logic [32:0] dd_q;
  logic [32:0] dr_q;
  logic [5:0]  dcnt_q;
  logic [63:0] sn_q, sres_q, sbit_q;

  logic        div_start, sqrt_start;
  logic [63:0] div_num;
  logic [32:0] div_den;

  logic        out_valid_q;
  logic [191:0] out_data_q;
  logic        out_snap_q;

  logic        in_fire;
  logic [30:0] st_in;
  logic signed [31:0] den_c;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign st_in   = (smooth_time_q < 31'(MINS)) ? 31'(MINS) : smooth_time_q;
  assign den_c   = (sat32(acc_q) < 32'sd1) ? 32'sd1 : sat32(acc_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_fire) state_d = S_OMEGA_DIV;
      S_OMEGA_DIV: if (!div_run_q) state_d = S_X_MUL;
      S_X_MUL:     state_d = S_X_WB;
      S_X_WB:      state_d = S_X2_MUL;
      S_X2_MUL:    state_d = S_X2_WB;
      S_X2_WB:     state_d = S_X3_MUL;
      S_X3_MUL:    state_d = S_X3_WB;
      S_X3_WB:     state_d = S_CSQ_MUL;
      S_CSQ_MUL:   state_d = S_CSQ_WB;
      S_CSQ_WB:    state_d = S_CCU_MUL;
      S_CCU_MUL:   state_d = S_CCU_WB;
      S_CCU_WB:    state_d = S_DEN;
      S_DEN:       state_d = S_EX_DIV;
      S_EX_DIV:    if (!div_run_q) state_d = S_CHG;
      S_CHG:       state_d = S_SQ_MUL;
      S_SQ_MUL:    state_d = S_SQ_WB;
      S_SQ_WB:     state_d = (idx_q == 2'd2) ? S_LIM_MUL : S_SQ_MUL;
      S_LIM_MUL:   state_d = S_LIM_WB;
      S_LIM_WB:    state_d = S_LSQ_MUL;
      S_LSQ_MUL:   state_d = S_LSQ_WB;
      S_LSQ_WB:    state_d = (magsq_q > unsigned'(p_q)) ? S_SQRT : S_A_MUL;
      S_SQRT:      if (!sqrt_run_q) state_d = S_SC_MUL;
      S_SC_MUL:    state_d = S_SC_START;
      S_SC_START:  state_d = S_SC_DIV;
      S_SC_DIV:    if (!div_run_q) state_d = (idx_q == 2'd2) ? S_A_MUL : S_SC_MUL;
      S_A_MUL:     state_d = S_A_WB;
      S_A_WB:      state_d = S_T_MUL;
      S_T_MUL:     state_d = S_T_WB;
      S_T_WB:      state_d = S_C_MUL;
      S_C_MUL:     state_d = S_C_WB;
      S_C_WB:      state_d = S_V_MUL;
      S_V_MUL:     state_d = S_V_WB;
      S_V_WB:      state_d = S_F_MUL;
      S_F_MUL:     state_d = S_F_WB;
      S_F_WB:      state_d = S_O_PRE;
      S_O_PRE:     state_d = S_O_MUL;
      S_O_MUL:     state_d = S_O_WB;
      S_O_WB:      state_d = (idx_q == 2'd2) ? S_DONE : S_A_MUL;
      S_DONE:      if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Control outputs: multiplier operands and unit starts.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_num    = '0;
    div_den    = '0;
    s_axis_tready = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        div_start = in_fire;
        div_num   = NUM_OMEGA;
        div_den   = {2'b0, st_in};
      end
      S_X_MUL:   begin mul_a = omega_q; mul_b = $signed({16'b0, dt_q}); end
      S_X2_MUL:  begin mul_a = x_q; mul_b = x_q; end
      S_X3_MUL:  begin mul_a = x2_q; mul_b = x_q; end
      S_CSQ_MUL: begin mul_a = 32'(COEF_SQ); mul_b = x2_q; end
      S_CCU_MUL: begin mul_a = 32'(COEF_CU); mul_b = x3_q; end
      S_DEN: begin
        div_start = 1'b1;
        div_num   = NUM_EX;
        div_den   = {1'b0, den_c};
      end
      S_SQ_MUL:  begin mul_a = chg_q[idx_q]; mul_b = chg_q[idx_q]; end
      S_LIM_MUL: begin
        mul_a = $signed({1'b0, max_speed_q});
        mul_b = $signed({1'b0, st_q});
      end
      S_LSQ_MUL: begin mul_a = limit_q; mul_b = limit_q; end
      S_LSQ_WB:  sqrt_start = (magsq_q > unsigned'(p_q));
      S_SC_MUL:  begin mul_a = chg_q[idx_q]; mul_b = limit_q; end
      S_SC_START: begin
        div_start = 1'b1;
        div_num   = p_q[63] ? unsigned'(-p_q) : unsigned'(p_q);
        div_den   = mag_q;
      end
      S_A_MUL:   begin mul_a = omega_q; mul_b = chg_q[idx_q]; end
      S_T_MUL:   begin mul_a = t_q; mul_b = $signed({16'b0, dt_q}); end
      S_C_MUL:   begin mul_a = omega_q; mul_b = tmp_q; end
      S_V_MUL:   begin mul_a = t_q; mul_b = ex_q; end
      S_F_MUL:   begin mul_a = t_q; mul_b = ex_q; end
      S_O_MUL:   begin mul_a = gmc_q[idx_q]; mul_b = t_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_time_q <= 31'd65536;
      max_speed_q   <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SMOOTH_TIME) smooth_time_q <= cfg_data_i;
      if (cfg_idx_i == CFG_MAX_SPEED)   max_speed_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Restoring divider, one quotient bit per cycle.
  logic [33:0] dr_sh;
  assign dr_sh = {dr_q, dq_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
      dcnt_q    <= '0;
    end else if (div_start) begin
      div_run_q <= 1'b1;
      dcnt_q    <= '0;
    end else if (div_run_q) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (dcnt_q == '1) div_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dq_q <= div_num;
      dd_q <= div_den;
      dr_q <= '0;
    end else if (div_run_q) begin
      if (dr_sh >= {1'b0, dd_q}) begin
        dr_q <= 33'(dr_sh - {1'b0, dd_q});
        dq_q <= {dq_q[62:0], 1'b1};
      end else begin
        dr_q <= dr_sh[32:0];
        dq_q <= {dq_q[62:0], 1'b0};
      end
    end
  end

  // Integer square root, two radicand bits per cycle.
  logic [63:0] sq_sum;
  assign sq_sum = sres_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqrt_run_q <= 1'b0;
    end else if (sqrt_start) begin
      sqrt_run_q <= 1'b1;
    end else if (sqrt_run_q && sbit_q[0]) begin
      sqrt_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_start) begin
      sn_q   <= magsq_q;
      sres_q <= '0;
      sbit_q <= 64'(1) << 62;
    end else if (sqrt_run_q) begin
      if (sn_q >= sq_sum) begin
        sn_q   <= sn_q - sq_sum;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // Datapath writes by sequencer step.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_fire) begin
        for (int i = 0; i < 3; i++) begin
          cur_q[i]  <= $signed(s_axis_tdata[32*i +: 32]);
          goal_q[i] <= $signed(s_axis_tdata[96 + 32*i +: 32]);
        end
        dt_q <= (s_axis_tdata[207:192] == '0) ? 16'd1 : s_axis_tdata[207:192];
        st_q <= st_in;
      end
      S_OMEGA_DIV: if (!div_run_q) omega_q <= usat32(dq_q);
      S_X_WB:   x_q <= qsh(p_q, 16);
      S_X2_WB: begin
        x2_q  <= qsh(p_q, FRAC_BITS);
        acc_q <= 66'(QONE) + 66'(x_q);
      end
      S_X3_WB:  x3_q <= qsh(p_q, FRAC_BITS);
      S_CSQ_WB: acc_q <= acc_q + 66'(qsh(p_q, FRAC_BITS));
      S_CCU_WB: acc_q <= acc_q + 66'(qsh(p_q, FRAC_BITS));
      S_EX_DIV: if (!div_run_q) ex_q <= usat32(dq_q);
      S_CHG: begin
        for (int i = 0; i < 3; i++) begin
          chg_q[i] <= sub32(cur_q[i], goal_q[i]);
          gmc_q[i] <= sub32(goal_q[i], cur_q[i]);
        end
        magsq_q <= '0;
        acc_q   <= '0;
        idx_q   <= '0;
      end
      S_SQ_WB: begin
        magsq_q <= magsq_q + unsigned'(p_q);
        idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      S_LIM_WB: limit_q <= qsh(p_q, FRAC_BITS);
      S_SQRT: if (!sqrt_run_q) begin
        mag_q <= (sres_q[32:0] == '0) ? 33'd1 : sres_q[32:0];
      end
      S_SC_START: neg_q <= p_q[63];
      S_SC_DIV: if (!div_run_q) begin
        chg_q[idx_q] <= neg_q ? sat32(-$signed({2'b0, dq_q})) : sat32({2'b0, dq_q});
        idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      S_A_WB: begin
        t_q    <= add32(vel_q[idx_q], qsh(p_q, FRAC_BITS));
        base_q <= sub32(cur_q[idx_q], chg_q[idx_q]);
      end
      S_T_WB:  tmp_q <= qsh(p_q, 16);
      S_C_WB:  t_q <= sub32(vel_q[idx_q], qsh(p_q, FRAC_BITS));
      S_V_WB: begin
        nvel_q[idx_q] <= qsh(p_q, FRAC_BITS);
        t_q <= add32(chg_q[idx_q], tmp_q);
      end
      S_F_WB:  nxt_q[idx_q] <= add32(base_q, qsh(p_q, FRAC_BITS));
      S_O_PRE: t_q <= sub32(nxt_q[idx_q], goal_q[idx_q]);
      S_O_WB: begin
        acc_q <= acc_q + 66'(p_q);
        idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Result register and kept velocity.
  logic done_fire, over;
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign over      = (acc_q > 66'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) vel_q[i] <= '0;
    end else begin
      if (done_fire) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < 3; i++) vel_q[i] <= over ? 32'sd0 : nvel_q[i];
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      for (int i = 0; i < 3; i++) begin
        out_data_q[32*i +: 32]      <= over ? goal_q[i] : nxt_q[i];
        out_data_q[96 + 32*i +: 32] <= over ? 32'sd0 : nvel_q[i];
      end
      out_snap_q <= over;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_snap_q;

  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!div_run_q && !sqrt_run_q))
    else $error("input ready while an arithmetic unit is busy");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_run_q && sqrt_run_q))
    else $error("divider and square root run together");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("ready stayed high after accepting a beat");

  a_snap_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire && over |=> (m_axis_tdata[191:96] == '0 && m_axis_tuser))
    else $error("snapped result carries a nonzero velocity");

endmodule
`default_nettype wire
